// ===== rtl/plst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_pkg
// Shared types and constants for the positional list store.
// ----------------------------------------------------------------------------
package plst_pkg;

   localparam int OP_W   = 2;
   localparam int POS_W  = 7;
   localparam int WORD_W = 32;
   localparam int LEN_W  = 7;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_RETRIEVE = 2'd2
   } plst_op_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic              insert;
      logic              remove;
      logic [POS_W-1:0]  slot;
      logic [WORD_W-1:0] value;
   } plst_cmd_type;

endpackage

// ===== rtl/plst_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_req_if / plst_rsp_if
// Valid/ready channels for list operations and their responses.
// ----------------------------------------------------------------------------
interface plst_req_if;
   import plst_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          opcode;
   logic [POS_W-1:0]         position;
   logic signed [WORD_W-1:0] value;

   modport source (output valid, output opcode, output position, output value, input ready);
   modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface plst_rsp_if;
   import plst_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     ok;
   logic signed [WORD_W-1:0] data;
   logic [LEN_W-1:0]         length;
   logic                     is_empty;

   modport source (output valid, output ok, output data, output length, output is_empty,
                   input ready);
   modport sink   (input valid, input ok, input data, input length, input is_empty,
                   output ready);
endinterface

// ===== rtl/plst_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_cell
// One list slot: holds a word, loads it, or takes a neighbor's word on a shift.
// ----------------------------------------------------------------------------
module plst_cell
   import plst_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  plst_cmd_type      cmd,
   input  logic [WORD_W-1:0] left_q,
   input  logic [WORD_W-1:0] right_q,
   output logic [WORD_W-1:0] q,
   output logic [WORD_W-1:0] rd_q
);

   logic [WORD_W-1:0] entry_ff;
   logic [WORD_W-1:0] entry_in;
   logic [31:0]       idx;
   logic [31:0]       slot;

   assign idx  = 32'(INDEX);
   assign slot = 32'(cmd.slot);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (idx == slot) begin
            entry_in = cmd.value;
         end else if (idx > slot) begin
            entry_in = left_q;
         end
      end else if (cmd.remove && idx >= slot) begin
         entry_in = right_q;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q    = entry_ff;
   assign rd_q = (idx == slot) ? entry_ff : '0;

endmodule

// ===== rtl/positional_list_store_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_core
// Ordered list of words with insert, remove and retrieve at a 1-based position.
// The response is registered in the cycle after the request transaction.
// One transaction per cycle unless stalled; only cells from the slot up shift.
// Reset: synchronous; list length goes to zero, no response pending.
// Entry storage is not cleared; only positions below the length are read.
// ----------------------------------------------------------------------------
module positional_list_store_core
   import plst_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input logic          clock,
   input logic          reset,
   plst_req_if.sink     req_bus,
   plst_rsp_if.source   rsp_bus
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   logic              ok_ff;
   logic              ok_in;
   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;
   logic [LEN_W-1:0]  length_ff;
   logic              empty_ff;

   logic              accept;
   logic [EXT_W-1:0]  count_ext;
   logic [EXT_W-1:0]  count_next_ext;
   logic [EXT_W-1:0]  slot_ext;
   logic              pos_nz;
   logic              full;
   logic              ins_ok;
   logic              rem_ok;
   logic              ret_ok;
   plst_op_type       op;
   plst_cmd_type      cmd;
   logic [WORD_W-1:0] rd_or;

   logic [WORD_W-1:0] cell_q  [CAPACITY];
   logic [WORD_W-1:0] cell_rd [CAPACITY];

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign op        = plst_op_type'(req_bus.opcode);
   assign count_ext = EXT_W'(count_ff);
   assign slot_ext  = EXT_W'(req_bus.position) - EXT_W'(1);
   assign pos_nz    = (req_bus.position != '0);
   assign full      = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      ins_ok = 1'b0;
      rem_ok = 1'b0;
      ret_ok = 1'b0;
      case (op)
         OP_INSERT:   ins_ok = !full && pos_nz && (slot_ext <= count_ext);
         OP_REMOVE:   rem_ok = pos_nz && (slot_ext < count_ext);
         OP_RETRIEVE: ret_ok = pos_nz && (slot_ext < count_ext);
         default: begin
            ins_ok = 1'b0;
            rem_ok = 1'b0;
            ret_ok = 1'b0;
         end
      endcase
   end

   assign cmd.insert = accept && ins_ok;
   assign cmd.remove = accept && rem_ok;
   assign cmd.slot   = req_bus.position - POS_W'(1);
   assign cmd.value  = req_bus.value;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         plst_cell #(
            .INDEX (gi)
         ) u_cell (
            .clock   (clock),
            .cmd     (cmd),
            .left_q  ((gi == 0) ? req_bus.value : cell_q[(gi == 0) ? 0 : gi - 1]),
            .right_q ((gi == CAPACITY - 1) ? cell_q[gi]
                                            : cell_q[(gi == CAPACITY - 1) ? gi : gi + 1]),
            .q       (cell_q[gi]),
            .rd_q    (cell_rd[gi])
         );
      end
   endgenerate

   always_comb begin
      rd_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_or = rd_or | cell_rd[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign count_next_ext = EXT_W'(count_in);
   assign ok_in          = ins_ok || rem_ok || ret_ok;
   assign data_in        = ret_ok ? rd_or : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff     <= ok_in;
         data_ff   <= data_in;
         length_ff <= count_next_ext[LEN_W-1:0];
         empty_ff  <= (count_in == '0);
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.ok       = ok_ff;
   assign rsp_bus.data     = data_ff;
   assign rsp_bus.length   = length_ff;
   assign rsp_bus.is_empty = empty_ff;

endmodule
